@@ rtl/gpsel_pkg.sv @@
// ----------------------------------------------------------------------------
// gpsel_pkg
// Shared constants, codes and types of the parent selection engine.
// ----------------------------------------------------------------------------
package gpsel_pkg;

	localparam int POP_DEPTH = 1024;
	localparam int IDX_W     = 10;
	localparam int SIZE_W    = 11;
	localparam int FIT_W     = 17;
	localparam int SUM_W     = 27;
	localparam int FRAC_W    = 16;
	localparam int TLEN_W    = 5;
	localparam int CMD_W     = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOAD       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_FINALIZE   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ROULETTE   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_UNIFORM    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_TOURNAMENT = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POP_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TLEN     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OS_EN    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OS_BND   = 2'd3;

	// register reset values
	localparam logic [SIZE_W-1:0] POP_SIZE_RST = 11'd512;
	localparam logic [TLEN_W-1:0] TLEN_RST     = 5'd2;
	localparam logic [FRAC_W-1:0] OS_BND_RST   = 16'd20972;

	localparam logic [SIZE_W-1:0] POP_MAX   = 11'd1024;
	localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
	localparam logic [FIT_W-1:0]  FRAC_ONE  = 17'h10000;
	// 0.8 test: 5 * bias < 4 << FRAC_W
	localparam logic [FRAC_W+2:0] BIAS_LIMIT = 19'h40000;

	// result kinds
	localparam logic RES_INDEX = 1'b0;
	localparam logic RES_TOTAL = 1'b1;

	typedef struct packed {
		logic [SIZE_W-1:0] pop_cnt;
		logic [TLEN_W-1:0] tlen;
		logic              os_en;
		logic [FRAC_W-1:0] os_bnd;
	} cfg_t;

	typedef struct packed {
		logic             kind;
		logic [IDX_W-1:0] index;
		logic [SUM_W-1:0] total;
	} res_t;

endpackage

@@ rtl/gpsel_req_if.sv @@
// ----------------------------------------------------------------------------
// gpsel_req_if
// Request channel: command and operands, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gpsel_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [gpsel_pkg::CMD_W-1:0]          command;
	logic [gpsel_pkg::IDX_W-1:0]          entry_index;
	logic [gpsel_pkg::FIT_W-1:0]          fitness_value;
	logic [gpsel_pkg::FRAC_W-1:0]         draw_main;
	logic [gpsel_pkg::FRAC_W-1:0]         draw_bias;

	modport source (output valid, command, entry_index, fitness_value, draw_main,
		draw_bias, input ready);
	modport sink (input valid, command, entry_index, fitness_value, draw_main,
		draw_bias, output ready);
endinterface

@@ rtl/gpsel_res_if.sv @@
// ----------------------------------------------------------------------------
// gpsel_res_if
// Result channel: selected index or finalize total, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gpsel_res_if;
	logic                          valid;
	logic                          ready;
	logic                          result_kind;
	logic [gpsel_pkg::IDX_W-1:0]   chosen_index;
	logic [gpsel_pkg::SUM_W-1:0]   total_fitness;

	modport source (output valid, result_kind, chosen_index, total_fitness,
		input ready);
	modport sink (input valid, result_kind, chosen_index, total_fitness,
		output ready);
endinterface

@@ rtl/gpsel_ram.sv @@
// ----------------------------------------------------------------------------
// gpsel_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gpsel_ram #(
	parameter int WIDTH = gpsel_pkg::FIT_W,
	parameter int DEPTH = gpsel_pkg::POP_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/gpsel_core.sv @@
// ----------------------------------------------------------------------------
// gpsel_core
// Sequencer over the fitness and cumulative memories: load, finalize
// (optional selection sort and running sums), roulette, uniform, tournament.
// ----------------------------------------------------------------------------
module gpsel_core (
	input  logic                clk,
	input  logic                arst_n,
	input  gpsel_pkg::cfg_t     cfg,
	gpsel_req_if.sink           request,
	output logic                res_valid,
	output gpsel_pkg::res_t     res,
	input  logic                res_ready
);
	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] S_IDLE      = 4'd0;
	localparam logic [ST_W-1:0] S_FIN_START = 4'd1;
	localparam logic [ST_W-1:0] S_FIN_SCAN  = 4'd2;
	localparam logic [ST_W-1:0] S_FIN_WR_I  = 4'd3;
	localparam logic [ST_W-1:0] S_FIN_WR_TP = 4'd4;
	localparam logic [ST_W-1:0] S_RL_MUL    = 4'd5;
	localparam logic [ST_W-1:0] S_RL_PROD   = 4'd6;
	localparam logic [ST_W-1:0] S_RL_SCAN   = 4'd7;
	localparam logic [ST_W-1:0] S_UNI       = 4'd8;
	localparam logic [ST_W-1:0] S_TN_RD_J   = 4'd9;
	localparam logic [ST_W-1:0] S_TN_RD_W   = 4'd10;
	localparam logic [ST_W-1:0] S_TN_CMP    = 4'd11;
	localparam logic [ST_W-1:0] S_RESULT    = 4'd12;

	localparam int IW = gpsel_pkg::IDX_W;
	localparam int NW = gpsel_pkg::SIZE_W;
	localparam int FW = gpsel_pkg::FIT_W;
	localparam int SW = gpsel_pkg::SUM_W;
	localparam int DW = gpsel_pkg::FRAC_W;
	localparam int PW = FW + SW;

	logic [ST_W-1:0] state_q;
	logic [NW-1:0]   n_q;
	logic [DW-1:0]   draw_q;
	logic [DW-1:0]   bias_q;
	logic [NW-1:0]   i_q;
	logic [NW-1:0]   issue_q;
	logic            pend_s1;
	logic [IW-1:0]   pj_s1;
	logic            first_q;
	logic [FW-1:0]   max_q;
	logic [FW-1:0]   old_q;
	logic [IW-1:0]   top_q;
	logic [SW-1:0]   acc_q;
	logic [SW-1:0]   total_q;
	logic [FW-1:0]   f_q;
	logic [PW-1:0]   target_q;
	logic [IW-1:0]   winner_q;
	logic [gpsel_pkg::TLEN_W-1:0] tcount_q;
	logic [IW-1:0]   j_q;
	logic [FW-1:0]   fj_q;
	gpsel_pkg::res_t res_q;

	logic            fit_we, cum_we;
	logic [IW-1:0]   fit_waddr, fit_raddr, cum_waddr, cum_raddr;
	logic [FW-1:0]   fit_wdata, fit_rdata;
	logic [SW-1:0]   cum_wdata, cum_rdata;

	logic            accept;
	logic [NW-1:0]   live_n;
	logic [NW-1:0]   scan_limit;
	logic            scan_more;
	logic [SW:0]     acc_sum;
	logic [SW-1:0]   acc_sat;
	logic [DW+NW-1:0] uni_prod;
	logic [IW-1:0]   uni;
	logic            bias_low;
	logic [FW-1:0]   mul_op;
	logic [DW+FW-1:0] os_prod;
	logic [FW-1:0]   f_next;
	logic            hit;
	logic [gpsel_pkg::TLEN_W-1:0] tlen_eff;
	logic [gpsel_pkg::TLEN_W-1:0] tcount_inc;
	logic            tn_take;
	logic [IW-1:0]   winner_next;

	gpsel_ram #(.WIDTH(FW), .DEPTH(gpsel_pkg::POP_DEPTH)) u_fit_ram (
		.clk(clk), .we(fit_we), .waddr(fit_waddr), .wdata(fit_wdata),
		.raddr(fit_raddr), .rdata(fit_rdata)
	);

	gpsel_ram #(.WIDTH(SW), .DEPTH(gpsel_pkg::POP_DEPTH)) u_cum_ram (
		.clk(clk), .we(cum_we), .waddr(cum_waddr), .wdata(cum_wdata),
		.raddr(cum_raddr), .rdata(cum_rdata)
	);

	assign request.ready = (state_q == S_IDLE);
	assign accept        = request.valid && request.ready;
	assign res_valid     = (state_q == S_RESULT);
	assign res           = res_q;

	// clamp the population size
	always_comb begin
		if (cfg.pop_cnt == '0) begin
			live_n = NW'(1);
		end else if (cfg.pop_cnt > gpsel_pkg::POP_MAX) begin
			live_n = gpsel_pkg::POP_MAX;
		end else begin
			live_n = cfg.pop_cnt;
		end
	end

	// uniform pick: floor(draw * n)
	assign uni_prod = {{NW{1'b0}}, draw_q} * {{DW{1'b0}}, n_q};
	assign uni      = uni_prod[DW+IW-1:DW];

	// scan bound: whole live range when sorting or searching, one entry otherwise
	always_comb begin
		if (state_q == S_FIN_SCAN) begin
			scan_limit = cfg.os_en ? n_q : NW'(i_q + NW'(1));
		end else begin
			scan_limit = n_q;
		end
	end
	assign scan_more = (issue_q < scan_limit);

	// saturating running sum
	assign acc_sum = {1'b0, acc_q} + {{(SW+1-FW){1'b0}}, max_q};
	assign acc_sat = acc_sum[SW] ? gpsel_pkg::SUM_MAX : acc_sum[SW-1:0];

	// overselection position
	assign bias_low = ({3'b000, bias_q} + {1'b0, bias_q, 2'b00}) < gpsel_pkg::BIAS_LIMIT;
	assign mul_op   = bias_low ? {1'b0, cfg.os_bnd} : FW'(gpsel_pkg::FRAC_ONE - {1'b0, cfg.os_bnd});
	assign os_prod  = {{FW{1'b0}}, draw_q} * {{DW{1'b0}}, mul_op};
	always_comb begin
		if (!cfg.os_en) begin
			f_next = {1'b0, draw_q};
		end else if (bias_low) begin
			f_next = os_prod[DW+FW-1:DW];
		end else begin
			f_next = FW'({1'b0, cfg.os_bnd} + os_prod[DW+FW-1:DW]);
		end
	end

	assign hit = target_q <= {1'b0, cum_rdata, {DW{1'b0}}};

	// tournament compare
	assign tlen_eff    = (cfg.tlen == '0) ? gpsel_pkg::TLEN_W'(1) : cfg.tlen;
	assign tcount_inc  = tcount_q + gpsel_pkg::TLEN_W'(1);
	assign tn_take     = (tcount_q == '0) || (fj_q > fit_rdata);
	assign winner_next = tn_take ? j_q : winner_q;

	// memory port steering
	always_comb begin
		fit_we    = 1'b0;
		fit_waddr = i_q[IW-1:0];
		fit_wdata = max_q;
		fit_raddr = issue_q[IW-1:0];
		cum_we    = 1'b0;
		cum_waddr = i_q[IW-1:0];
		cum_wdata = acc_sat;
		cum_raddr = issue_q[IW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (accept && request.command == gpsel_pkg::CMD_LOAD) begin
					fit_we    = 1'b1;
					fit_waddr = request.entry_index;
					fit_wdata = request.fitness_value;
				end
			end
			S_FIN_WR_I: begin
				fit_we = 1'b1;
				cum_we = 1'b1;
			end
			S_FIN_WR_TP: begin
				fit_we    = 1'b1;
				fit_waddr = top_q;
				fit_wdata = old_q;
			end
			S_TN_RD_J: fit_raddr = uni;
			S_TN_RD_W: fit_raddr = winner_q;
			default: begin
			end
		endcase
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pend_s1  <= 1'b0;
			total_q  <= '0;
			winner_q <= '0;
			tcount_q <= '0;
		end else begin
			pend_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						n_q    <= live_n;
						draw_q <= request.draw_main;
						bias_q <= request.draw_bias;
						i_q    <= '0;
						acc_q  <= '0;
						priority case (request.command)
							gpsel_pkg::CMD_FINALIZE:   state_q <= S_FIN_START;
							gpsel_pkg::CMD_ROULETTE:   state_q <= S_RL_MUL;
							gpsel_pkg::CMD_UNIFORM:    state_q <= S_UNI;
							gpsel_pkg::CMD_TOURNAMENT: state_q <= S_TN_RD_J;
							default:                   state_q <= S_IDLE;
						endcase
					end
				end
				S_FIN_START: begin
					if (i_q == n_q) begin
						total_q <= acc_q;
						res_q   <= '{kind: gpsel_pkg::RES_TOTAL, index: '0, total: acc_q};
						state_q <= S_RESULT;
					end else begin
						issue_q <= i_q;
						first_q <= 1'b1;
						state_q <= S_FIN_SCAN;
					end
				end
				S_FIN_SCAN: begin
					// issue one read a cycle, take the max of the returned data
					if (scan_more) begin
						pend_s1 <= 1'b1;
						pj_s1   <= issue_q[IW-1:0];
						issue_q <= issue_q + NW'(1);
					end
					if (pend_s1) begin
						first_q <= 1'b0;
						if (first_q) begin
							old_q <= fit_rdata;
							max_q <= fit_rdata;
							top_q <= pj_s1;
						end else if (fit_rdata > max_q) begin
							max_q <= fit_rdata;
							top_q <= pj_s1;
						end
					end
					if (!scan_more && !pend_s1) begin
						state_q <= S_FIN_WR_I;
					end
				end
				S_FIN_WR_I: begin
					acc_q <= acc_sat;
					if (top_q != i_q[IW-1:0]) begin
						state_q <= S_FIN_WR_TP;
					end else begin
						i_q     <= i_q + NW'(1);
						state_q <= S_FIN_START;
					end
				end
				S_FIN_WR_TP: begin
					i_q     <= i_q + NW'(1);
					state_q <= S_FIN_START;
				end
				S_RL_MUL: begin
					f_q     <= f_next;
					state_q <= S_RL_PROD;
				end
				S_RL_PROD: begin
					target_q <= {{SW{1'b0}}, f_q} * {{FW{1'b0}}, total_q};
					issue_q  <= '0;
					state_q  <= S_RL_SCAN;
				end
				S_RL_SCAN: begin
					// first slot whose sum reaches f * total (f: draw or overselection position); uniform pick if none
					if (scan_more) begin
						pend_s1 <= 1'b1;
						pj_s1   <= issue_q[IW-1:0];
						issue_q <= issue_q + NW'(1);
					end
					if (pend_s1 && hit) begin
						res_q   <= '{kind: gpsel_pkg::RES_INDEX, index: pj_s1, total: '0};
						state_q <= S_RESULT;
					end else if (!scan_more && !pend_s1) begin
						res_q   <= '{kind: gpsel_pkg::RES_INDEX, index: uni, total: '0};
						state_q <= S_RESULT;
					end
				end
				S_UNI: begin
					res_q   <= '{kind: gpsel_pkg::RES_INDEX, index: uni, total: '0};
					state_q <= S_RESULT;
				end
				S_TN_RD_J: begin
					j_q     <= uni;
					state_q <= S_TN_RD_W;
				end
				S_TN_RD_W: begin
					fj_q    <= fit_rdata;
					state_q <= S_TN_CMP;
				end
				S_TN_CMP: begin
					winner_q <= winner_next;
					if (tcount_inc < tlen_eff) begin
						tcount_q <= tcount_inc;
						state_q  <= S_IDLE;
					end else begin
						tcount_q <= '0;
						res_q    <= '{kind: gpsel_pkg::RES_INDEX, index: winner_next, total: '0};
						state_q  <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/gp_parent_selection_engine.sv @@
// ----------------------------------------------------------------------------
// gp_parent_selection_engine
// Parent selection for a genetic-programming population.
//
// Requests arrive on the request channel (command, slot, fitness, two draws);
// results leave on the result channel (kind, chosen slot, total). Registers
// are written through cfg_we / cfg_index / cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce. One
// request is worked at a time, sequenced over two 1024-deep memories
// (fitness and cumulative sums), one read port each:
//   load        no result
//   uniform     floor(draw * n)
//   tournament  one draw per request; the last draw reports the winner
//   roulette    linear scan from slot 0 to the chosen slot, one read a cycle,
//               up to the population size
//   finalize    running sums, one entry per slot plain; with overselection
//               the selection sort scans n - i entries for each slot i
// Reset clears the control state and registers to their defaults; memories
// hold nothing meaningful until loaded. A stalled receiver holds the result
// in the output register; the next request is taken while it waits.
// ----------------------------------------------------------------------------
module gp_parent_selection_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	gpsel_req_if.sink                           request,
	gpsel_res_if.source                         result,
	input  logic                                cfg_we,
	input  logic [gpsel_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gpsel_pkg::CFG_DAT_W-1:0]     cfg_data
);
	gpsel_pkg::cfg_t cfg_q;
	gpsel_pkg::res_t core_res;
	gpsel_pkg::res_t out_q;
	logic            core_valid;
	logic            core_ready;
	logic            out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pop_cnt <= gpsel_pkg::POP_SIZE_RST;
			cfg_q.tlen    <= gpsel_pkg::TLEN_RST;
			cfg_q.os_en   <= 1'b0;
			cfg_q.os_bnd  <= gpsel_pkg::OS_BND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gpsel_pkg::REG_POP_SIZE: cfg_q.pop_cnt <= cfg_data[gpsel_pkg::SIZE_W-1:0];
				gpsel_pkg::REG_TLEN:     cfg_q.tlen    <= cfg_data[gpsel_pkg::TLEN_W-1:0];
				gpsel_pkg::REG_OS_EN:    cfg_q.os_en   <= cfg_data[0];
				gpsel_pkg::REG_OS_BND:   cfg_q.os_bnd  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	gpsel_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.request(request),
		.res_valid(core_valid),
		.res(core_res),
		.res_ready(core_ready)
	);

	// output register: load when empty or being drained
	assign core_ready = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_ready) begin
			out_valid_q <= core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (core_ready && core_valid) begin
			out_q <= core_res;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.result_kind   = out_q.kind;
	assign result.chosen_index  = out_q.index;
	assign result.total_fitness = out_q.total;
endmodule

@@ tb/tb_gp_parent_selection_engine.sv @@
// ----------------------------------------------------------------------------
// tb_gp_parent_selection_engine
// Self-checking bench for the parent selection engine: a queue-fed driver
// and a clocked monitor, an in-bench predictor of stores, sums and
// tournament state, and phases of register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_gp_parent_selection_engine;
	import gpsel_pkg::*;

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [IDX_W-1:0]  slot;
		logic [FIT_W-1:0]  fit;
		logic [FRAC_W-1:0] draw;
		logic [FRAC_W-1:0] bias;
	} sel_req_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	gpsel_req_if req_ch();
	gpsel_res_if res_ch();

	gp_parent_selection_engine DUT (
		.clk(clk),
		.arst_n(arst_n),
		.request(req_ch),
		.result(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	sel_req_t pending_reqs[$];
	res_t     expected_picks[$];
	int       error_count = 0;
	int       idle_mode = 0;
	logic     hold_start = 1'b0;
	int       hold_left = 0;

	// predictor copy of registers and state
	logic [SIZE_W-1:0] pm_size = POP_SIZE_RST;
	logic [TLEN_W-1:0] pm_tlen = TLEN_RST;
	logic              pm_os   = 1'b0;
	logic [FRAC_W-1:0] pm_bnd  = OS_BND_RST;
	logic [FIT_W-1:0]  pm_fit[POP_DEPTH];
	logic [SUM_W-1:0]  pm_cum[POP_DEPTH];
	logic [SUM_W-1:0]  pm_total = '0;
	logic [IDX_W-1:0]  pm_winner = '0;
	logic [TLEN_W-1:0] pm_count = '0;

	// generator view of which store entries hold defined data
	bit gen_fit_ok[POP_DEPTH];
	bit gen_cum_ok[POP_DEPTH];

	function automatic int live_n();
		if (pm_size == 0) return 1;
		if (pm_size > POP_MAX) return POP_DEPTH;
		return int'(pm_size);
	endfunction

	function automatic int uniform_slot(logic [FRAC_W-1:0] draw, int n);
		return int'((longint'(draw) * n) >>> FRAC_W);
	endfunction

	function automatic bit all_fit_ok(int n);
		for (int k = 0; k < n; k++) if (!gen_fit_ok[k]) return 0;
		return 1;
	endfunction

	function automatic bit all_cum_ok(int n);
		for (int k = 0; k < n; k++) if (!gen_cum_ok[k]) return 0;
		return 1;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		error_count++;
	endtask

	// work out the result of one accepted request
	task automatic predict_selection(sel_req_t r);
		int n;
		int top;
		int pick;
		longint acc;
		longint f;
		longint b;
		logic [FIT_W-1:0] tmp;
		res_t res;
		n = live_n();
		res = '0;
		case (r.cmd)
			CMD_LOAD: begin
				pm_fit[r.slot] = r.fit;
				return;
			end
			CMD_FINALIZE: begin
				acc = 0;
				for (int i = 0; i < n; i++) begin
					if (pm_os) begin
						top = i;
						for (int j = i + 1; j < n; j++)
							if (pm_fit[j] > pm_fit[top]) top = j;
						tmp = pm_fit[i];
						pm_fit[i] = pm_fit[top];
						pm_fit[top] = tmp;
					end
					acc += pm_fit[i];
					if (acc > SUM_MAX) acc = SUM_MAX;
					pm_cum[i] = acc[SUM_W-1:0];
				end
				pm_total = acc[SUM_W-1:0];
				res.kind = RES_TOTAL;
				res.total = pm_total;
				expected_picks.push_back(res);
				return;
			end
			CMD_ROULETTE: begin
				f = r.draw;
				b = pm_bnd;
				if (pm_os) begin
					if (longint'(r.bias) * 5 < longint'(BIAS_LIMIT))
						f = (longint'(r.draw) * b) >>> FRAC_W;
					else
						f = b + ((longint'(r.draw) * (longint'(FRAC_ONE) - b)) >>> FRAC_W);
				end
				pick = -1;
				for (int j = 0; j < n && pick < 0; j++)
					if (f * longint'(pm_total) <= (longint'(pm_cum[j]) <<< FRAC_W))
						pick = j;
				if (pick < 0) pick = uniform_slot(r.draw, n);
			end
			CMD_UNIFORM: pick = uniform_slot(r.draw, n);
			CMD_TOURNAMENT: begin
				pick = uniform_slot(r.draw, n);
				if (pm_count == 0 || pm_fit[pick] > pm_fit[pm_winner])
					pm_winner = pick[IDX_W-1:0];
				pm_count = pm_count + 1'b1;
				if (pm_count < ((pm_tlen == 0) ? 1 : pm_tlen)) return;
				pm_count = '0;
				pick = pm_winner;
			end
			default: return;
		endcase
		res.kind = RES_INDEX;
		res.index = pick[IDX_W-1:0];
		expected_picks.push_back(res);
	endtask

	// clock, reset and known input levels
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.command = '0;
		req_ch.entry_index = '0;
		req_ch.fitness_value = '0;
		req_ch.draw_main = '0;
		req_ch.draw_bias = '0;
		res_ch.ready = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic bit sender_idles();
		if (idle_mode == 1) return $urandom_range(0, 99) < 52;
		if (idle_mode == 3) return $urandom_range(0, 99) < 8;
		return 0;
	endfunction

	function automatic bit receiver_stalls();
		if (idle_mode == 2) return $urandom_range(0, 99) < 52;
		if (idle_mode == 3) return $urandom_range(0, 99) < 8;
		return 0;
	endfunction

	// driver: predict on acceptance, then offer the next request
	always @(posedge clk or negedge arst_n) begin
		sel_req_t nx;
		sel_req_t acc_req;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				acc_req.cmd  = req_ch.command;
				acc_req.slot = req_ch.entry_index;
				acc_req.fit  = req_ch.fitness_value;
				acc_req.draw = req_ch.draw_main;
				acc_req.bias = req_ch.draw_bias;
				predict_selection(acc_req);
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_reqs.size() != 0 && !sender_idles()) begin
					nx = pending_reqs.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.command <= nx.cmd;
					req_ch.entry_index <= nx.slot;
					req_ch.fitness_value <= nx.fit;
					req_ch.draw_main <= nx.draw;
					req_ch.draw_bias <= nx.bias;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted in cycles
	always @(posedge clk) begin
		if (hold_start) hold_left <= 600;
		else if (hold_left != 0) hold_left <= hold_left - 1;
	end

	// monitor: check each accepted result against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		res_t exp_r;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_picks.size() == 0) begin
					report_mismatch("result with no expectation");
				end else begin
					exp_r = expected_picks.pop_front();
					if (res_ch.result_kind !== exp_r.kind)
						report_mismatch($sformatf("kind %0b, expected %0b",
							res_ch.result_kind, exp_r.kind));
					if (res_ch.chosen_index !== exp_r.index)
						report_mismatch($sformatf("index %0d, expected %0d",
							res_ch.chosen_index, exp_r.index));
					if (res_ch.total_fitness !== exp_r.total)
						report_mismatch($sformatf("total %0d, expected %0d",
							res_ch.total_fitness, exp_r.total));
				end
			end
			res_ch.ready <= !(hold_start || hold_left > 1 || receiver_stalls());
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DAT_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_POP_SIZE: pm_size = value[SIZE_W-1:0];
			REG_TLEN:     pm_tlen = value[TLEN_W-1:0];
			REG_OS_EN:    pm_os   = value[0];
			default:      pm_bnd  = value[FRAC_W-1:0];
		endcase
	endtask

	task automatic set_regs(int size, int tlen, int os, int bnd);
		write_reg(REG_POP_SIZE, size);
		write_reg(REG_TLEN, tlen);
		write_reg(REG_OS_EN, os);
		write_reg(REG_OS_BND, bnd);
	endtask

	task automatic queue_req(logic [CMD_W-1:0] cmd, int slot, int fit, int draw, int bias);
		sel_req_t r;
		r.cmd = cmd;
		r.slot = slot[IDX_W-1:0];
		r.fit = fit[FIT_W-1:0];
		r.draw = draw[FRAC_W-1:0];
		r.bias = bias[FRAC_W-1:0];
		if (cmd == CMD_LOAD) gen_fit_ok[r.slot] = 1;
		if (cmd == CMD_FINALIZE)
			for (int k = 0; k < live_n(); k++) gen_cum_ok[k] = 1;
		pending_reqs.push_back(r);
	endtask

	function automatic int rand_fit();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return int'(FRAC_ONE);
		if (r < 10) return 0;
		return $urandom_range(0, int'(FRAC_ONE));
	endfunction

	// one random phase: fill the live slots when there are at most 64, then a random mix that includes undefined codes
	task automatic queue_random(int count);
		int n;
		int r;
		logic [CMD_W-1:0] cmd;
		n = live_n();
		if (n <= 64)
			for (int k = 0; k < n; k++)
				if (!gen_fit_ok[k]) queue_req(CMD_LOAD, k, rand_fit(), $urandom, $urandom);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 28) cmd = CMD_LOAD;
			else if (r < 36) cmd = all_fit_ok(n) ? CMD_FINALIZE : CMD_UNIFORM;
			else if (r < 60) cmd = all_cum_ok(n) ? CMD_ROULETTE : CMD_UNIFORM;
			else if (r < 70) cmd = CMD_UNIFORM;
			else if (r < 94) cmd = all_fit_ok(n) ? CMD_TOURNAMENT : CMD_UNIFORM;
			else cmd = CMD_TOURNAMENT + 3'($urandom_range(1, 3));
			if (cmd == CMD_LOAD)
				queue_req(cmd, ($urandom_range(0, 99) < 70) ? $urandom_range(0, n - 1)
					: $urandom_range(0, POP_DEPTH - 1), rand_fit(), $urandom, $urandom);
			else
				queue_req(cmd, $urandom_range(0, POP_DEPTH - 1), rand_fit(), $urandom, $urandom);
		end
	endtask

	// let the block drain: requests sent, results in, trailing no-result work done
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || req_ch.valid || expected_picks.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic run_phase(int size, int tlen, int os, int bnd, int mode, int count,
		bit squeeze);
		set_regs(size, tlen, os, bnd);
		idle_mode = mode;
		if (squeeze) begin
			@(posedge clk);
			hold_start <= 1'b1;
			@(posedge clk);
			hold_start <= 1'b0;
		end
		queue_random(count);
		wait_drained();
	endtask

	// stimulus sequence
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);

		// directed: field extremes, every command, plain roulette
		set_regs(8, 2, 0, 20972);
		queue_req(CMD_LOAD, 0, 0, 0, 0);
		queue_req(CMD_LOAD, 1, int'(FRAC_ONE), 0, 0);
		queue_req(CMD_LOAD, 2, 1, 0, 0);
		queue_req(CMD_LOAD, 3, 65535, 0, 0);
		queue_req(CMD_LOAD, 4, 12345, 0, 0);
		queue_req(CMD_LOAD, 5, int'(FRAC_ONE), 0, 0);
		queue_req(CMD_LOAD, 6, 7, 0, 0);
		queue_req(CMD_LOAD, 7, 40000, 0, 0);
		queue_req(CMD_LOAD, POP_DEPTH - 1, 99, 0, 0);
		queue_req(CMD_FINALIZE, 0, 0, 0, 0);
		queue_req(CMD_ROULETTE, 0, 0, 0, 0);
		queue_req(CMD_ROULETTE, 0, 0, 65535, 65535);
		queue_req(CMD_UNIFORM, 0, 0, 0, 0);
		queue_req(CMD_UNIFORM, 0, 0, 65535, 0);
		queue_req(CMD_TOURNAMENT, 0, 0, 9000, 0);
		queue_req(CMD_TOURNAMENT, 0, 0, 65535, 0);
		queue_req(CMD_TOURNAMENT + 3'd1, 0, 0, 0, 0);
		queue_req(CMD_TOURNAMENT + 3'd2, 0, 0, 0, 0);
		queue_req(CMD_TOURNAMENT + 3'd3, 0, 0, 0, 0);
		wait_drained();

		// directed: sorted finalize, bias on both sides of 0.8
		write_reg(REG_OS_EN, 1);
		queue_req(CMD_FINALIZE, 0, 0, 0, 0);
		queue_req(CMD_ROULETTE, 0, 0, 30000, 52428);
		queue_req(CMD_ROULETTE, 0, 0, 30000, 52429);
		queue_req(CMD_ROULETTE, 0, 0, 65535, 0);
		queue_req(CMD_ROULETTE, 0, 0, 0, 65535);
		wait_drained();

		run_phase(5, 3, 0, 20972, 1, 120, 0);
		run_phase(1, 1, 1, 0, 2, 80, 0);
		run_phase(0, 0, 0, 65535, 3, 80, 0);
		run_phase(33, 16, 1, 65535, 0, 120, 1);
		run_phase(64, 2, 1, 13107, 1, 150, 0);
		run_phase(2047, 31, 0, 100, 2, 60, 0);
		run_phase(1024, 5, 1, 40000, 3, 60, 0);
		run_phase(16, 4, 1, 20972, 2, 150, 0);
		run_phase(47, 7, 0, 30000, 0, 120, 0);

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// watchdog
	initial begin
		#80000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
